// ----- sv/bsdc_pkg.sv -----
// Package for the byte sorter with duplicate check.
// Holds the beat payload types and the command and status types that
// join the controller and the datapath. No dependencies.
package bsdc_pkg;

    typedef struct packed {
        logic signed [7:0] char_value;
        logic              is_last;
    } chr_beat_t;

    typedef struct packed {
        logic signed [7:0] sorted_value;
        logic              end_of_run;
        logic              all_distinct;
        logic              overflowed;
    } srt_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic pop;
    } bsdc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic one_left;
    } bsdc_stat_t;

endpackage

// ----- sv/byte_sorter_with_duplicate_check.sv -----
// Byte sorter with duplicate check: keeps signed bytes in ascending order.
// Loading takes one byte per cycle; every cell compares the byte at once.
// After the last byte, the emit phase loads results into the output register,
// one per cycle unless stalled; input stalls until the last result is loaded.
// Reset clears the fill count, the flags and the controller; the cells keep
// whatever they hold, since only filled cells are ever read.
module byte_sorter_with_duplicate_check
    import bsdc_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      chr_valid,
    output logic      chr_stall,
    input  chr_beat_t chr_data,
    output logic      srt_valid,
    input  logic      srt_stall,
    output srt_beat_t srt_data
);

    bsdc_cmd_t  cmd;
    bsdc_stat_t stat;

    bsdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .is_last   (chr_data.is_last),
        .chr_stall (chr_stall),
        .srt_valid (srt_valid),
        .srt_stall (srt_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bsdc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_value (chr_data.char_value),
        .stat       (stat),
        .srt_data   (srt_data)
    );

    // A waiting result beat holds still until it is taken.
    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (srt_valid && srt_stall) |=> (srt_valid && $stable(srt_data))
    ) else $error("result beat changed while stalled");

    // The run flags stay the same from one result beat to the next within a run.
    a_flags_steady: assert property (
        @(posedge clk) disable iff (!rst_n)
        (srt_valid && !srt_stall && !srt_data.end_of_run) |=>
            (!srt_valid ||
             ((srt_data.all_distinct == $past(srt_data.all_distinct)) &&
              (srt_data.overflowed == $past(srt_data.overflowed))))
    ) else $error("run flags changed within a run");

    // Loading and emitting never happen in the same cycle.
    a_no_overlap: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(cmd.insert && cmd.pop)
    ) else $error("insert and pop in the same cycle");

endmodule

// ----- sv/bsdc_datapath.sv -----
// Datapath of the byte sorter: the insertion chain of cells, the fill count,
// the duplicate and overflow flags and the result register.
// Depends on bsdc_pkg.
module bsdc_datapath
    import bsdc_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  bsdc_cmd_t  cmd,
    input  logic signed [7:0] char_value,
    output bsdc_stat_t stat,
    output srt_beat_t  srt_data
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic signed [7:0] cell_reg  [MAX_LEN];
    logic signed [7:0] cell_next [MAX_LEN];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              dup_reg;
    logic              dup_next;
    logic              ovf_reg;
    logic              ovf_next;
    srt_beat_t         out_reg;
    srt_beat_t         out_next;

    logic [MAX_LEN-1:0] vld;
    logic [MAX_LEN-1:0] gt;
    logic [MAX_LEN-1:0] eq;
    logic               full;
    logic               one_left;

    assign full     = (count_reg == CW'(MAX_LEN));
    assign one_left = (count_reg == CW'(1));

    // Every cell compares itself against the incoming byte at once.
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            vld[i] = (CW'(i) < count_reg);
            gt[i]  = vld[i] && (cell_reg[i] > char_value);
            eq[i]  = vld[i] && (cell_reg[i] == char_value);
        end
    end

    // A cell keeps its byte when that byte is not greater than the new one.
    // Cells past the insertion point take their left neighbor, and the
    // first of them takes the new byte. Equal bytes land after equal ones.
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (cmd.pop)
        begin
            for (int i = 0; i < MAX_LEN - 1; i++)
            begin
                cell_next[i] = cell_reg[i + 1];
            end
        end
        else if (cmd.insert && !full)
        begin
            if (!(vld[0] && !gt[0]))
            begin
                cell_next[0] = char_value;
            end
            for (int i = 1; i < MAX_LEN; i++)
            begin
                if (vld[i] && !gt[i])
                begin
                    cell_next[i] = cell_reg[i];
                end
                else if (gt[i - 1])
                begin
                    cell_next[i] = cell_reg[i - 1];
                end
                else
                begin
                    cell_next[i] = char_value;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        dup_next   = dup_reg;
        ovf_next   = ovf_reg;
        out_next   = out_reg;
        if (cmd.pop)
        begin
            out_next.sorted_value = cell_reg[0];
            out_next.end_of_run   = one_left;
            out_next.all_distinct = !dup_reg;
            out_next.overflowed   = ovf_reg;
            count_next            = count_reg - CW'(1);
            if (one_left)
            begin
                dup_next = 1'b0;
                ovf_next = 1'b0;
            end
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                dup_next   = dup_reg | (|eq);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dup_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            dup_reg   <= dup_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign stat.one_left = one_left;
    assign srt_data      = out_reg;

endmodule

// ----- sv/bsdc_ctrl.sv -----
// Controller of the byte sorter: load and emit phases, the input stall and
// the valid bit of the result register.
// Depends on bsdc_pkg.
module bsdc_ctrl
    import bsdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       chr_valid,
    input  logic       is_last,
    output logic       chr_stall,
    output logic       srt_valid,
    input  logic       srt_stall,
    input  bsdc_stat_t stat,
    output bsdc_cmd_t  cmd
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic valid_reg;
    logic valid_next;
    logic accept;
    logic pop;

    assign chr_stall = (state_reg != ST_LOAD);
    assign accept    = chr_valid && !chr_stall;

    // In the emit phase, a result moves into the output register whenever it is
    // empty or its beat is being taken in this cycle.
    assign pop = (state_reg == ST_EMIT) && (!valid_reg || !srt_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (pop && stat.one_left)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && srt_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign cmd.insert = accept;
    assign cmd.pop    = pop;
    assign srt_valid  = valid_reg;

endmodule
